// ===== design/ahfb_pkg.sv =====
// ----------------------------------------------------------------------------
// ahfb_pkg: shared definitions of the ASCII hex frame builder
// Request codes, the job record that travels from front to back, framing
// characters, sizes and the hex digit encoder.
// ----------------------------------------------------------------------------
package ahfb_pkg;

    localparam int MAX_DATA_BYTES = 16;
    localparam int CNT_W          = $clog2(MAX_DATA_BYTES + 1);
    localparam int AVAIL_W        = (CNT_W > 4) ? CNT_W : 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SOX  = 8'h01;
    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [1:0] {
        REQ_OPEN  = 2'd0,
        REQ_DATA  = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        t_req        kind;
        logic [3:0]  station;
        logic [7:0]  command_code;
        logic [7:0]  data_number;
        logic [63:0] data_value;
        logic [3:0]  nbytes;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        case (v)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage

// ===== design/ascii_hex_frame_builder_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_builder_unit: ASCII hex frame builder, top level
// Streams an ASCII hex frame with an additive checksum, one byte per beat.
// ----------------------------------------------------------------------------
// Usage: each input beat is a request. An open request emits seven bytes
// (SOX, station character, two command digits, STX, two data number digits).
// A data request emits two hex digits per appended byte, up to sixteen bytes,
// and nothing once the frame holds its data byte limit. A close request emits
// ETX and two checksum digits, the last marked with o_frame_end. o_run_last
// marks the last byte of each request. Requests that emit nothing are dropped.
// The front takes a request into a two-entry job queue. Each request that is
// kept emits 2 to 16 bytes. The back sequencer sends one byte per cycle while
// the receiver does not stall; when the block is idle the first byte passes
// through the queue, the sequencer's job register and the output register.
// When the receiver stalls, the output register holds its byte, the back
// waits and the queue fills, after which o_ready falls. Synchronous reset
// clears the queue, the output valid and the frame state.
// ----------------------------------------------------------------------------
module ascii_hex_frame_builder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_station,
    input  logic [7:0]  i_command_code,
    input  logic [7:0]  i_data_number,
    input  logic [63:0] i_data_value,
    input  logic [3:0]  i_value_bytes,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_frame_end
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    ahfb_pkg::t_job push_job;
    ahfb_pkg::t_job head_job;

    ahfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_station      (i_station),
        .i_command_code (i_command_code),
        .i_data_number  (i_data_number),
        .i_data_value   (i_data_value),
        .i_value_bytes  (i_value_bytes),
        .i_full         (full),
        .o_push         (push),
        .o_job          (push_job)
    );

    ahfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    ahfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== design/ahfb_front.sv =====
// ----------------------------------------------------------------------------
// ahfb_front: request intake
// Accepts input beats, tracks frame state and data byte count, drops requests
// that emit nothing and pushes the rest as jobs into the queue.
// ----------------------------------------------------------------------------
module ahfb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_req_type,
    input  logic [3:0]          i_station,
    input  logic [7:0]          i_command_code,
    input  logic [7:0]          i_data_number,
    input  logic [63:0]         i_data_value,
    input  logic [3:0]          i_value_bytes,
    input  logic                i_full,
    output logic                o_push,
    output ahfb_pkg::t_job      o_job
);

    logic                       r_open;
    logic [ahfb_pkg::CNT_W-1:0] r_cnt;
    logic                       n_open;
    logic [ahfb_pkg::CNT_W-1:0] n_cnt;
    logic                       accept;
    logic [3:0]                 clamp;
    logic [ahfb_pkg::AVAIL_W-1:0] avail;
    logic [3:0]                 nb;
    logic [2:0]                 pad;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign clamp = (i_value_bytes > 4'd8) ? 4'd8 : i_value_bytes;
    assign avail = ahfb_pkg::AVAIL_W'(ahfb_pkg::MAX_DATA_BYTES)
                 - ahfb_pkg::AVAIL_W'(r_cnt);
    assign nb    = (avail < ahfb_pkg::AVAIL_W'(clamp)) ? avail[3:0] : clamp;
    assign pad   = 3'(4'd8 - clamp);

    always_comb begin
        n_open             = r_open;
        n_cnt              = r_cnt;
        o_push             = 1'b0;
        o_job.kind         = ahfb_pkg::t_req'(i_req_type);
        o_job.station      = i_station;
        o_job.command_code = i_command_code;
        o_job.data_number  = i_data_number;
        o_job.data_value   = i_data_value << {pad, 3'b000};
        o_job.nbytes       = nb;
        if (accept) begin
            unique case (ahfb_pkg::t_req'(i_req_type))
                ahfb_pkg::REQ_OPEN: begin
                    n_open = 1'b1;
                    n_cnt  = '0;
                    o_push = 1'b1;
                end
                ahfb_pkg::REQ_DATA: begin
                    if (r_open && nb != 4'd0) begin
                        o_push = 1'b1;
                        n_cnt  = r_cnt + ahfb_pkg::CNT_W'(nb);
                    end
                end
                ahfb_pkg::REQ_CLOSE: begin
                    if (r_open) begin
                        o_push = 1'b1;
                        n_open = 1'b0;
                        n_cnt  = '0;
                    end
                end
                ahfb_pkg::REQ_NONE: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_open <= n_open;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== design/ahfb_queue.sv =====
// ----------------------------------------------------------------------------
// ahfb_queue: job queue
// A short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module ahfb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ahfb_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ahfb_pkg::t_job o_job
);

    ahfb_pkg::t_job              r_mem [ahfb_pkg::QUEUE_DEPTH];
    logic [ahfb_pkg::QPTR_W-1:0] r_wr;
    logic [ahfb_pkg::QPTR_W-1:0] r_rd;
    logic [ahfb_pkg::QCNT_W-1:0] r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_cnt == ahfb_pkg::QCNT_W'(ahfb_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == ahfb_pkg::QPTR_W'(ahfb_pkg::QUEUE_DEPTH - 1))
                      ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == ahfb_pkg::QPTR_W'(ahfb_pkg::QUEUE_DEPTH - 1))
                      ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/ahfb_back.sv =====
// ----------------------------------------------------------------------------
// ahfb_back: byte sequencer
// Takes queued jobs, steps through their bytes one per cycle unless stalled,
// keeps the running checksum and drives the registered output channel.
// ----------------------------------------------------------------------------
module ahfb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ahfb_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_frame_end
);

    logic           r_busy;
    ahfb_pkg::t_job r_job;
    logic [3:0]     r_step;
    logic [3:0]     r_last_step;
    logic [7:0]     r_sum;
    logic           r_valid;
    logic [7:0]     r_byte;
    logic           r_run_last;
    logic           r_frame_end;
    logic           emit;
    logic           at_last;
    logic [7:0]     byte_c;
    logic           add_c;
    logic [7:0]     top;

    assign emit    = r_busy && (!r_valid || i_ready);
    assign at_last = (r_step == r_last_step);
    assign o_pop   = !i_empty && (!r_busy || (emit && at_last));
    assign top     = r_job.data_value[63:56];

    always_comb begin
        byte_c = 8'h00;
        add_c  = 1'b0;
        case (r_job.kind)
            ahfb_pkg::REQ_OPEN: begin
                add_c = (r_step != 4'd0);
                case (r_step)
                    4'd0:    byte_c = ahfb_pkg::CH_SOX;
                    4'd1:    byte_c = ahfb_pkg::CH_ZERO + {4'h0, r_job.station};
                    4'd2:    byte_c = ahfb_pkg::hex_char(r_job.command_code[7:4]);
                    4'd3:    byte_c = ahfb_pkg::hex_char(r_job.command_code[3:0]);
                    4'd4:    byte_c = ahfb_pkg::CH_STX;
                    4'd5:    byte_c = ahfb_pkg::hex_char(r_job.data_number[7:4]);
                    default: byte_c = ahfb_pkg::hex_char(r_job.data_number[3:0]);
                endcase
            end
            ahfb_pkg::REQ_DATA: begin
                add_c  = 1'b1;
                byte_c = r_step[0] ? ahfb_pkg::hex_char(top[3:0])
                                   : ahfb_pkg::hex_char(top[7:4]);
            end
            ahfb_pkg::REQ_CLOSE: begin
                add_c = (r_step == 4'd0);
                case (r_step)
                    4'd0:    byte_c = ahfb_pkg::CH_ETX;
                    4'd1:    byte_c = ahfb_pkg::hex_char(r_sum[7:4]);
                    default: byte_c = ahfb_pkg::hex_char(r_sum[3:0]);
                endcase
            end
            default: begin
                byte_c = 8'h00;
                add_c  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            case (i_job.kind)
                ahfb_pkg::REQ_OPEN:  r_last_step <= 4'd6;
                ahfb_pkg::REQ_CLOSE: r_last_step <= 4'd2;
                default:             r_last_step <= {3'(i_job.nbytes - 4'd1), 1'b1};
            endcase
        end else if (emit && r_job.kind == ahfb_pkg::REQ_DATA && r_step[0]) begin
            r_job.data_value <= r_job.data_value << 8;
        end
        if (emit) begin
            r_byte      <= byte_c;
            r_run_last  <= at_last;
            r_frame_end <= at_last && (r_job.kind == ahfb_pkg::REQ_CLOSE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_step  <= r_step + 1'b1;
                if (r_job.kind == ahfb_pkg::REQ_OPEN && r_step == 4'd0) begin
                    r_sum <= '0;
                end else if (r_job.kind == ahfb_pkg::REQ_CLOSE && at_last) begin
                    r_sum <= '0;
                end else if (add_c) begin
                    r_sum <= r_sum + byte_c;
                end
                if (at_last) begin
                    r_busy <= 1'b0;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_run_last  = r_run_last;
    assign o_frame_end = r_frame_end;

endmodule

// ===== design/ahfb_checker.sv =====
// ----------------------------------------------------------------------------
// ahfb_checker: port checks of the frame builder
// Concurrent checks on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
module ahfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_frame_end
);

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_run_last)
        else $error("frame end beat without run last");

    a_end_is_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |->
            ((o_out_byte >= 8'h30 && o_out_byte <= 8'h39) ||
             (o_out_byte >= 8'h41 && o_out_byte <= 8'h46)))
        else $error("checksum digit is not an upper-case hex character");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte)
            && $stable(o_run_last) && $stable(o_frame_end))
        else $error("stalled output beat changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind ascii_hex_frame_builder_unit ahfb_checker u_ahfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_byte  (o_out_byte),
    .o_run_last  (o_run_last),
    .o_frame_end (o_frame_end)
);

// ===== tb/sv/ahfb_frame_checker.sv =====
// ----------------------------------------------------------------------------
// ahfb_frame_checker: line byte predictor and scoreboard
// Watches the request and byte channels of the ASCII hex frame builder. Each
// accepted request is expanded into the bytes it should put on the line, and
// each accepted output beat is compared field by field with the oldest of
// them. The failure count, the number of bytes still owed and the number of
// beats checked are handed to the testbench top.
// ----------------------------------------------------------------------------
module ahfb_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_station,
    input  logic [7:0]  i_command_code,
    input  logic [7:0]  i_data_number,
    input  logic [63:0] i_data_value,
    input  logic [3:0]  i_value_bytes,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_run_last,
    input  logic        i_frame_end,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_beat_count
);

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       frame_end;
    } t_line_byte;

    t_line_byte  line_bytes_due[$];
    logic [7:0]  frame_sum;
    int unsigned frame_data_bytes;
    logic        frame_live;
    int          fail_total;
    int          beats_seen;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_beat_count = 0;
        fail_total = 0;
        beats_seen = 0;
        frame_sum = '0;
        frame_data_bytes = 0;
        frame_live = 1'b0;
    end

    function automatic logic [7:0] ascii_nibble(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h37 + {4'd0, v};
    endfunction

    task automatic push_line_byte(input logic [7:0] b, input logic counted);
        line_bytes_due.push_back('{value: b, run_last: 1'b0, frame_end: 1'b0});
        if (counted) begin
            frame_sum = frame_sum + b;
        end
    endtask

    task automatic push_hex_pair(input logic [7:0] v, input logic counted);
        push_line_byte(ascii_nibble(v[7:4]), counted);
        push_line_byte(ascii_nibble(v[3:0]), counted);
    endtask

    task automatic predict_frame_bytes(
        input ahfb_pkg::t_req kind,
        input logic [3:0]     station,
        input logic [7:0]     command_code,
        input logic [7:0]     data_number,
        input logic [63:0]    data_value,
        input logic [3:0]     value_bytes
    );
        int         first;
        int         take;
        logic [7:0] sum_now;
        t_line_byte tail;
        first = line_bytes_due.size();
        case (kind)
            ahfb_pkg::REQ_OPEN: begin
                frame_sum = '0;
                frame_data_bytes = 0;
                frame_live = 1'b1;
                push_line_byte(ahfb_pkg::CH_SOX, 1'b0);
                push_line_byte(ahfb_pkg::CH_ZERO + {4'd0, station}, 1'b1);
                push_hex_pair(command_code, 1'b1);
                push_line_byte(ahfb_pkg::CH_STX, 1'b1);
                push_hex_pair(data_number, 1'b1);
            end
            ahfb_pkg::REQ_DATA: begin
                if (frame_live) begin
                    take = (value_bytes > 4'd8) ? 8 : int'(value_bytes);
                    for (int i = take; i > 0; i--) begin
                        if (frame_data_bytes >= ahfb_pkg::MAX_DATA_BYTES) begin
                            break;
                        end
                        frame_data_bytes++;
                        push_hex_pair(data_value[8*(i-1) +: 8], 1'b1);
                    end
                end
            end
            ahfb_pkg::REQ_CLOSE: begin
                if (frame_live) begin
                    push_line_byte(ahfb_pkg::CH_ETX, 1'b1);
                    sum_now = frame_sum;
                    push_hex_pair(sum_now, 1'b0);
                    tail = line_bytes_due.pop_back();
                    tail.frame_end = 1'b1;
                    line_bytes_due.push_back(tail);
                    frame_sum = '0;
                    frame_data_bytes = 0;
                    frame_live = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (line_bytes_due.size() > first) begin
            tail = line_bytes_due.pop_back();
            tail.run_last = 1'b1;
            line_bytes_due.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin
        t_line_byte want;
        if (!i_rst_n) begin
            line_bytes_due.delete();
            frame_sum = '0;
            frame_data_bytes = 0;
            frame_live = 1'b0;
        end else begin
            if (i_byte_valid && i_byte_ready) begin
                beats_seen++;
                if (line_bytes_due.size() == 0) begin
                    $error("out_byte: nothing expected, got %h", i_out_byte);
                    fail_total++;
                end else begin
                    want = line_bytes_due.pop_front();
                    if (i_out_byte !== want.value) begin
                        $error("out_byte: expected %h, got %h", want.value, i_out_byte);
                        fail_total++;
                    end
                    if (i_run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, i_run_last);
                        fail_total++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %b, got %b", want.frame_end, i_frame_end);
                        fail_total++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_frame_bytes(ahfb_pkg::t_req'(i_req_type), i_station,
                                    i_command_code, i_data_number, i_data_value,
                                    i_value_bytes);
            end
        end
        o_pending <= line_bytes_due.size();
        o_fail_count <= fail_total;
        o_beat_count <= beats_seen;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level test of the ASCII hex frame builder
// Drives directed requests for the framing corner cases, then random frames
// with random content and some stray requests, with random gaps on the
// request side and random stalls on the byte side. The frame checker predicts
// and compares every byte; this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_REQUESTS = 140;

    logic        i_clk;
    logic        i_rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  req_type;
    logic [3:0]  req_station;
    logic [7:0]  req_command;
    logic [7:0]  req_data_number;
    logic [63:0] req_data_value;
    logic [3:0]  req_value_bytes;
    logic        byte_valid;
    logic        byte_ready;
    logic [7:0]  line_byte;
    logic        line_run_last;
    logic        line_frame_end;

    int fail_count;
    int bytes_owed;
    int beats_checked;
    int idle_cycles;
    int opens_sent;
    int data_sent;
    int closes_sent;
    int unused_sent;
    bit quiet;

    ascii_hex_frame_builder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (req_valid),
        .o_ready        (req_ready),
        .i_req_type     (req_type),
        .i_station      (req_station),
        .i_command_code (req_command),
        .i_data_number  (req_data_number),
        .i_data_value   (req_data_value),
        .i_value_bytes  (req_value_bytes),
        .o_valid        (byte_valid),
        .i_ready        (byte_ready),
        .o_out_byte     (line_byte),
        .o_run_last     (line_run_last),
        .o_frame_end    (line_frame_end)
    );

    ahfb_frame_checker frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .i_req_ready    (req_ready),
        .i_req_type     (req_type),
        .i_station      (req_station),
        .i_command_code (req_command),
        .i_data_number  (req_data_number),
        .i_data_value   (req_data_value),
        .i_value_bytes  (req_value_bytes),
        .i_byte_valid   (byte_valid),
        .i_byte_ready   (byte_ready),
        .i_out_byte     (line_byte),
        .i_run_last     (line_run_last),
        .i_frame_end    (line_frame_end),
        .o_fail_count   (fail_count),
        .o_pending      (bytes_owed),
        .o_beat_count   (beats_checked)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = ahfb_pkg::REQ_NONE;
        req_station = '0;
        req_command = '0;
        req_data_number = '0;
        req_data_value = '0;
        req_value_bytes = '0;
        byte_ready = 1'b0;
        quiet = 1'b0;
        idle_cycles = 0;
        opens_sent = 0;
        data_sent = 0;
        closes_sent = 0;
        unused_sent = 0;
    end

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        byte_ready <= quiet || ($urandom_range(0, 99) >= 38);
    end

    always @(posedge i_clk) begin
        if ((req_valid && req_ready) || (byte_valid && byte_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic send_request(
        input ahfb_pkg::t_req kind,
        input logic [3:0]     station,
        input logic [7:0]     command_code,
        input logic [7:0]     data_number,
        input logic [63:0]    data_value,
        input logic [3:0]     value_bytes
    );
        while (!quiet && $urandom_range(0, 99) < 38) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_type <= kind;
        req_station <= station;
        req_command <= command_code;
        req_data_number <= data_number;
        req_data_value <= data_value;
        req_value_bytes <= value_bytes;
        @(posedge i_clk);
        while (!req_ready) begin
            @(posedge i_clk);
        end
        case (kind)
            ahfb_pkg::REQ_OPEN: opens_sent++;
            ahfb_pkg::REQ_DATA: data_sent++;
            ahfb_pkg::REQ_CLOSE: closes_sent++;
            default: unused_sent++;
        endcase
    endtask

    task automatic send_random(input ahfb_pkg::t_req kind);
        logic [3:0] nbytes;
        if ($urandom_range(0, 9) == 0) begin
            nbytes = 4'($urandom_range(0, 15));
        end else begin
            nbytes = 4'($urandom_range(1, 8));
        end
        send_request(kind, 4'($urandom), 8'($urandom), 8'($urandom),
                     {$urandom, $urandom}, nbytes);
    endtask

    initial begin
        int counted;
        int data_items;
        int pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(ahfb_pkg::REQ_CLOSE, 4'h3, 8'h11, 8'h22, 64'h0, 4'd1);
        send_request(ahfb_pkg::REQ_DATA, 4'h3, 8'h11, 8'h22,
                     64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        send_request(ahfb_pkg::REQ_NONE, 4'hF, 8'hFF, 8'hFF,
                     64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
        send_request(ahfb_pkg::REQ_OPEN, 4'h0, 8'h00, 8'h00, 64'h0, 4'd0);
        send_request(ahfb_pkg::REQ_DATA, 4'h0, 8'h00, 8'h00,
                     64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        send_request(ahfb_pkg::REQ_DATA, 4'h0, 8'h00, 8'h00,
                     64'h1234_5678_9ABC_DEF0, 4'd0);
        send_request(ahfb_pkg::REQ_DATA, 4'h0, 8'h00, 8'h00,
                     64'h0123_4567_89AB_CDEF, 4'd15);
        send_request(ahfb_pkg::REQ_DATA, 4'h0, 8'h00, 8'h00,
                     64'h0000_0000_0000_00AA, 4'd1);
        send_request(ahfb_pkg::REQ_CLOSE, 4'h0, 8'h00, 8'h00, 64'h0, 4'd0);
        send_request(ahfb_pkg::REQ_OPEN, 4'hF, 8'hFF, 8'hFF, 64'h0, 4'd0);
        send_request(ahfb_pkg::REQ_OPEN, 4'h5, 8'hA5, 8'h5A, 64'h0, 4'd0);
        send_request(ahfb_pkg::REQ_DATA, 4'h5, 8'hA5, 8'h5A, 64'h0, 4'd1);
        send_request(ahfb_pkg::REQ_DATA, 4'h5, 8'hA5, 8'h5A,
                     64'h8000_0000_0000_0001, 4'd9);
        send_request(ahfb_pkg::REQ_NONE, 4'h5, 8'hA5, 8'h5A, 64'h0, 4'd4);
        send_request(ahfb_pkg::REQ_CLOSE, 4'h5, 8'hA5, 8'h5A, 64'h0, 4'd0);
        send_request(ahfb_pkg::REQ_CLOSE, 4'h5, 8'hA5, 8'h5A, 64'h0, 4'd0);
        send_request(ahfb_pkg::REQ_OPEN, 4'hA, 8'h3C, 8'hC3, 64'h0, 4'd0);
        send_request(ahfb_pkg::REQ_DATA, 4'hA, 8'h3C, 8'hC3,
                     64'hFEDC_BA98_7654_3210, 4'd4);
        send_request(ahfb_pkg::REQ_DATA, 4'hA, 8'h3C, 8'hC3,
                     64'h0F1E_2D3C_4B5A_6978, 4'd8);
        send_request(ahfb_pkg::REQ_DATA, 4'hA, 8'h3C, 8'hC3,
                     64'hC0DE_0000_0000_BEEF, 4'd8);
        send_request(ahfb_pkg::REQ_CLOSE, 4'hA, 8'h3C, 8'hC3, 64'h0, 4'd0);

        counted = 0;
        while (counted < RANDOM_REQUESTS) begin
            quiet = (counted >= 40) && (counted < 80);
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                send_random(ahfb_pkg::REQ_OPEN);
                counted++;
                data_items = $urandom_range(0, 6);
                repeat (data_items) begin
                    send_random(ahfb_pkg::REQ_DATA);
                    counted++;
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_random(ahfb_pkg::REQ_CLOSE);
                    counted++;
                end
            end else begin
                send_random(ahfb_pkg::t_req'($urandom_range(0, 3)));
                counted++;
            end
        end
        quiet = 1'b0;
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_owed != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Requests sent: %0d opens, %0d data, %0d closes, %0d unused codes.",
                 opens_sent, data_sent, closes_sent, unused_sent);
        $display("Line bytes compared: %0d, with idle and stall gaps on both sides.",
                 beats_checked);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
